@@ design/assert_macros.svh @@
// Assertion macros shared by the lookup table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that pre implies post in the same cycle.
`define SOL_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Checks that pre implies post in the following cycle.
`define SOL_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ design/sol_pkg.sv @@
// Types and constants shared by the self-organizing lookup table.
package sol_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 1024;

	localparam int KEY_W = 32;
	localparam int CNT_W = 32;
	localparam int POS_W = 10;
	localparam int LEN_W = 11;
	localparam int STRAT_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_STRATEGY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIST_LENGTH = 1'b1;

	// Reordering strategies.
	localparam logic [STRAT_W-1:0] STRAT_FRONT = 2'd0;
	localparam logic [STRAT_W-1:0] STRAT_TRANSPOSE = 2'd1;
	localparam logic [STRAT_W-1:0] STRAT_COUNT = 2'd2;

	// Command modes.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef struct packed {
		logic mode;
		logic [POS_W-1:0] index;
		logic [KEY_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic found;
		logic [POS_W-1:0] position;
	} res_t;

	// Table port controls from the sequencer.
	typedef struct packed {
		logic rd_en;
		logic wr_key_en;
		logic wr_cnt_en;
	} mem_ctl_t;

endpackage

@@ design/self_organizing_lookup_table.sv @@
// Top level of the self-organizing lookup table: configuration, output register.
//
// Command channel (cmd_valid, cmd_stall, cmd): a word is taken when cmd_valid is
// high and cmd_stall low. A load word writes a key at an index and clears its hit
// count; a lookup word scans entries from index zero for the first match.
// Result channel (res_valid, res_stall, res): one word per command with found and
// the position of the match before any reordering (zero on a miss or a load).
// Configuration: cfg_we with cfg_index and cfg_data writes strategy or
// list_length; the user writes only while the block is idle (not enforced).
// The scan reads one table entry per cycle through the single memory read port
// and the shared key comparator; a swap then writes in states WB1 and WB2. One
// command is in work at a time; the next word is taken only once its
// predecessor's result is written into the output register.
// After reset the hit count memory is swept to zero, one entry per cycle;
// cmd_stall stays high during the sweep.
// A stalled result waits in the output register; the block finishes its current
// command and holds it until the register is free.
`include "assert_macros.svh"

module self_organizing_lookup_table #(
	parameter int TABLE_DEPTH = sol_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  sol_pkg::cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output sol_pkg::res_t res,
	input  logic cfg_we,
	input  logic [sol_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sol_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sol_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [STRAT_W-1:0] strategy_q;
	logic [LEN_W-1:0] list_length_q;
	logic res_valid_q;
	res_t res_q;

	logic res_hold;
	logic resp_valid;
	res_t resp;
	mem_ctl_t mem_ctl;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [KEY_W-1:0] wr_key;
	logic [CNT_W-1:0] wr_cnt;
	logic [KEY_W-1:0] key_rd;
	logic [CNT_W-1:0] cnt_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= STRAT_FRONT;
			list_length_q <= LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRATEGY: strategy_q <= cfg_data[STRAT_W-1:0];
				REG_LIST_LENGTH: list_length_q <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign res_hold = res_valid_q && res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (resp_valid) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_valid) begin
			res_q <= resp;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	sol_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_stall(cmd_stall),
		.strategy(strategy_q),
		.list_length(list_length_q),
		.res_hold(res_hold),
		.resp_valid(resp_valid),
		.resp(resp),
		.mem_ctl(mem_ctl),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_key(wr_key),
		.wr_cnt(wr_cnt),
		.key_rd(key_rd),
		.cnt_rd(cnt_rd)
	);

	sol_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.mem_ctl(mem_ctl),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_key(wr_key),
		.wr_cnt(wr_cnt),
		.key_rd(key_rd),
		.cnt_rd(cnt_rd)
	);

	`SOL_ASSERT_SAME(a_no_result_overrun, clk, arst_n, resp_valid, !res_hold, "result written over a stalled word")
	`SOL_ASSERT_NEXT(a_result_shown, clk, arst_n, resp_valid, res_valid, "finished word not shown")
	`SOL_ASSERT_NEXT(a_stalled_held, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "stalled word changed")

endmodule

@@ design/sol_table.sv @@
// Key and hit count memories, one write port and one registered read port each.
module sol_table #(
	parameter int TABLE_DEPTH = sol_pkg::DEFAULT_TABLE_DEPTH,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic clk,
	input  sol_pkg::mem_ctl_t mem_ctl,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	input  logic [sol_pkg::KEY_W-1:0] wr_key,
	input  logic [sol_pkg::CNT_W-1:0] wr_cnt,
	output logic [sol_pkg::KEY_W-1:0] key_rd,
	output logic [sol_pkg::CNT_W-1:0] cnt_rd
);
	import sol_pkg::*;

	logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
	logic [CNT_W-1:0] cnt_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_key_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (mem_ctl.wr_cnt_en) begin
			cnt_mem[wr_addr] <= wr_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en) begin
			key_rd <= key_mem[rd_addr];
			cnt_rd <= cnt_mem[rd_addr];
		end
	end

endmodule

@@ design/sol_ctrl.sv @@
// Sequencer with the shared key compare and count update for the lookup table.
`include "assert_macros.svh"

module sol_ctrl #(
	parameter int TABLE_DEPTH = sol_pkg::DEFAULT_TABLE_DEPTH,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  sol_pkg::cmd_t cmd,
	output logic cmd_stall,
	input  logic [sol_pkg::STRAT_W-1:0] strategy,
	input  logic [sol_pkg::LEN_W-1:0] list_length,
	input  logic res_hold,
	output logic resp_valid,
	output sol_pkg::res_t resp,
	output sol_pkg::mem_ctl_t mem_ctl,
	output logic [AW-1:0] rd_addr,
	output logic [AW-1:0] wr_addr,
	output logic [sol_pkg::KEY_W-1:0] wr_key,
	output logic [sol_pkg::CNT_W-1:0] wr_cnt,
	input  logic [sol_pkg::KEY_W-1:0] key_rd,
	input  logic [sol_pkg::CNT_W-1:0] cnt_rd
);
	import sol_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_SCAN   = 7'b0000100,
		ST_DECIDE = 7'b0001000,
		ST_WB1    = 7'b0010000,
		ST_WB2    = 7'b0100000,
		ST_RESP   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic wb1_key;
		logic wb1_cnt;
		logic wb2_key;
		logic wb2_cnt;
	} plan_t;

	state_t st_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] len_q;
	logic rd_pend_s1;
	logic [AW-1:0] addr_s1;
	logic found_q;
	plan_t plan_q;
	logic [KEY_W-1:0] key_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] partner_q;
	logic [KEY_W-1:0] prev_key_q;
	logic [CNT_W-1:0] prev_cnt_q;
	logic [KEY_W-1:0] key0_q;
	logic [CNT_W-1:0] cur_cnt_q;
	logic [KEY_W-1:0] wb1_key_q;
	logic [CNT_W-1:0] wb1_cnt_q;
	logic [CNT_W-1:0] inc_q;

	logic accept;
	logic hit_now;
	logic more;
	logic issue;
	logic miss_now;
	logic pos_nz;
	logic load_ok;
	logic [31:0] idx_w;
	logic [31:0] len_w;
	logic [31:0] pos_w;
	logic [CNT_W-1:0] cnt_inc;
	plan_t plan_d;
	logic [KEY_W-1:0] wb1_key_d;
	logic [CNT_W-1:0] wb1_cnt_d;
	logic [AW-1:0] partner_d;

	assign accept = cmd_valid && (st_q == ST_IDLE);
	assign cmd_stall = (st_q != ST_IDLE);

	// The compare looks at the word read in the previous cycle.
	assign hit_now = (st_q == ST_SCAN) && rd_pend_s1 && (key_rd == key_q);
	assign more = (cnt_q < len_q);
	assign issue = (st_q == ST_SCAN) && !hit_now && more;
	assign miss_now = (st_q == ST_SCAN) && !rd_pend_s1 && !more;

	assign idx_w = 32'(cmd.index);
	assign load_ok = (idx_w < 32'(TABLE_DEPTH));
	assign len_w = (32'(list_length) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
		: 32'(list_length);
	assign pos_w = 32'(pos_q);

	assign pos_nz = (pos_q != '0);
	assign cnt_inc = (cur_cnt_q == '1) ? cur_cnt_q : cur_cnt_q + CNT_W'(1);

	always_comb begin
		plan_d = '0;
		wb1_key_d = prev_key_q;
		wb1_cnt_d = prev_cnt_q;
		partner_d = pos_q - AW'(1);
		unique case (strategy)
			STRAT_FRONT: begin
				if (pos_nz) begin
					plan_d.wb1_key = 1'b1;
					plan_d.wb2_key = 1'b1;
				end
				wb1_key_d = key0_q;
				partner_d = '0;
			end
			STRAT_TRANSPOSE: begin
				if (pos_nz) begin
					plan_d.wb1_key = 1'b1;
					plan_d.wb2_key = 1'b1;
				end
			end
			STRAT_COUNT: begin
				if (pos_nz && (prev_cnt_q < cnt_inc)) begin
					plan_d = '{wb1_key: 1'b1, wb1_cnt: 1'b1, wb2_key: 1'b1, wb2_cnt: 1'b1};
				end else begin
					plan_d.wb1_cnt = 1'b1;
					wb1_cnt_d = cnt_inc;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_ctl.rd_en = issue;
		mem_ctl.wr_key_en = 1'b0;
		mem_ctl.wr_cnt_en = 1'b0;
		rd_addr = cnt_q[AW-1:0];
		wr_addr = pos_q;
		wr_key = wb1_key_q;
		wr_cnt = wb1_cnt_q;
		unique case (st_q)
			ST_CLEAR: begin
				mem_ctl.wr_cnt_en = 1'b1;
				wr_addr = cnt_q[AW-1:0];
				wr_cnt = '0;
			end
			ST_WB1: begin
				mem_ctl.wr_key_en = plan_q.wb1_key;
				mem_ctl.wr_cnt_en = plan_q.wb1_cnt;
			end
			ST_WB2: begin
				mem_ctl.wr_key_en = plan_q.wb2_key;
				mem_ctl.wr_cnt_en = plan_q.wb2_cnt;
				wr_addr = partner_q;
				wr_key = key_q;
				wr_cnt = inc_q;
			end
			default: begin
			end
		endcase
	end

	assign resp_valid = (st_q == ST_RESP) && !res_hold;
	assign resp.found = found_q;
	assign resp.position = found_q ? pos_w[POS_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			cnt_q <= '0;
			rd_pend_s1 <= 1'b0;
			found_q <= 1'b0;
			plan_q <= '0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					if (cnt_q == CW'(TABLE_DEPTH - 1)) begin
						cnt_q <= '0;
						st_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						rd_pend_s1 <= 1'b0;
						found_q <= 1'b0;
						if (cmd.mode == MODE_LOAD) begin
							plan_q <= '{wb1_key: load_ok, wb1_cnt: load_ok,
								wb2_key: 1'b0, wb2_cnt: 1'b0};
							st_q <= ST_WB1;
						end else begin
							st_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_pend_s1 <= issue;
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (hit_now) begin
						found_q <= 1'b1;
						st_q <= ST_DECIDE;
					end else if (miss_now) begin
						st_q <= ST_RESP;
					end
				end
				ST_DECIDE: begin
					plan_q <= plan_d;
					st_q <= ST_WB1;
				end
				ST_WB1: begin
					st_q <= ST_WB2;
				end
				ST_WB2: begin
					st_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!res_hold) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= cmd.key;
			pos_q <= idx_w[AW-1:0];
			wb1_key_q <= cmd.key;
			wb1_cnt_q <= '0;
			len_q <= len_w[CW-1:0];
		end
		if (issue) begin
			addr_s1 <= cnt_q[AW-1:0];
		end
		// Keep the entry just passed, and entry zero, for the swap.
		if ((st_q == ST_SCAN) && rd_pend_s1 && !hit_now) begin
			prev_key_q <= key_rd;
			prev_cnt_q <= cnt_rd;
			if (addr_s1 == '0) begin
				key0_q <= key_rd;
			end
		end
		if (hit_now) begin
			pos_q <= addr_s1;
			cur_cnt_q <= cnt_rd;
		end
		if (st_q == ST_DECIDE) begin
			wb1_key_q <= wb1_key_d;
			wb1_cnt_q <= wb1_cnt_d;
			partner_q <= partner_d;
			inc_q <= cnt_inc;
		end
	end

	`SOL_ASSERT_SAME(a_hit_in_range, clk, arst_n, hit_now, 32'(addr_s1) < 32'(len_q), "hit beyond active length")
	`SOL_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, (st_q == ST_SCAN) || (st_q == ST_WB1), "accepted word did not start work")
	`SOL_ASSERT_SAME(a_miss_not_found, clk, arst_n, miss_now, !found_q, "miss with found flag set")

endmodule
